[hw/rtl/owbm_pkg.sv]
// owbm_pkg - shared types, register indexes and constants of the 1-wire bus master
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package owbm_pkg;

   localparam int CFG_W           = 12;
   localparam int CFG_NUM         = 8;
   localparam int CFG_IDX_W       = 4;
   localparam int COUNT_WIDTH_DEF = 12;
   localparam int REQ_TDATA_W     = 16;
   localparam int RSP_TDATA_W     = 16;

   // register indexes
   localparam int REG_RESET_LOW     = 0;
   localparam int REG_PRESENCE_WAIT = 1;
   localparam int REG_RESET_TAIL    = 2;
   localparam int REG_SHORT_LOW     = 3;
   localparam int REG_LONG_LOW      = 4;
   localparam int REG_READ_LOW      = 5;
   localparam int REG_READ_SAMPLE   = 6;
   localparam int REG_READ_TAIL     = 7;

   typedef logic [CFG_NUM-1:0][CFG_W-1:0] cfg_bank_type;

   // reset values, entry 0 in the lowest slot
   localparam cfg_bank_type CFG_RESET = {
      12'd50, 12'd5, 12'd5, 12'd60, 12'd3, 12'd500, 12'd70, 12'd500
   };

   // operation codes
   localparam logic [1:0] OP_RESET = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   typedef enum logic [8:0] {
      PH_IDLE     = 9'b000000001,
      PH_RST_LOW  = 9'b000000010,
      PH_RST_WAIT = 9'b000000100,
      PH_RST_TAIL = 9'b000001000,
      PH_WR_LOW   = 9'b000010000,
      PH_WR_HIGH  = 9'b000100000,
      PH_RD_LOW   = 9'b001000000,
      PH_RD_WAIT  = 9'b010000000,
      PH_RD_TAIL  = 9'b100000000
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [2:0] bit_index;
      logic [7:0] shift_out;
      logic [7:0] shift_in;
      logic       presence;
      logic [1:0] current_op;
   } seq_state_type;

   // request fields, lowest bit last
   typedef struct packed {
      logic       line_in;
      logic [7:0] write_byte;
      logic [1:0] func;
      logic       start_req;
   } req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       presence_bit;
      logic       done_res;
      logic       busy_res;
      logic       drive_low;
   } rsp_type;

endpackage

[hw/rtl/owbm_csr.sv]
// owbm_csr - slot timing register bank with its write port
// depends on owbm_pkg
`timescale 1ns / 1ps

module owbm_csr
   import owbm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   output cfg_bank_type         cfg
);

   cfg_bank_type cfg_ff;
   cfg_bank_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      for (int i = 0; i < CFG_NUM; i++) begin
         if (csr_valid && csr_index == CFG_IDX_W'(i)) begin
            cfg_in[i] = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/owbm_seq.sv]
// owbm_seq - next-state and result logic of the slot sequencer for one tick
// depends on owbm_pkg; purely combinational, the state lives in the top level
`timescale 1ns / 1ps

module owbm_seq
   import owbm_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  seq_state_type          state_cur,
   input  logic [COUNT_WIDTH-1:0] count_cur,
   input  req_type                req,
   input  cfg_bank_type           cfg,
   output seq_state_type          state_nxt,
   output logic [COUNT_WIDTH-1:0] count_nxt,
   output rsp_type                rsp
);

   localparam int CMP_W = (CFG_W > COUNT_WIDTH) ? CFG_W : COUNT_WIDTH;
   localparam logic [CMP_W-1:0] COUNT_TOP = CMP_W'((1 << COUNT_WIDTH) - 1);

   function automatic phase_type slot_start(input logic [1:0] op);
      phase_type ph;
      ph = PH_RST_LOW;
      if (op == OP_WRITE) begin
         ph = PH_WR_LOW;
      end else if (op == OP_READ) begin
         ph = PH_RD_LOW;
      end
      return ph;
   endfunction

   logic                   start_ok;
   seq_state_type          eff;
   logic [COUNT_WIDTH-1:0] tc;
   logic [COUNT_WIDTH-1:0] tick_inc;
   logic [CFG_W-1:0]       dur_raw;
   logic [CMP_W-1:0]       raw_ext;
   logic [CMP_W-1:0]       dur;
   logic                   reached;

   assign start_ok = state_cur.phase == PH_IDLE && req.start_req &&
                     (req.func == OP_RESET || req.func == OP_WRITE || req.func == OP_READ);

   // state as seen after a possible start on this tick
   always_comb begin
      eff = state_cur;
      tc  = count_cur;
      if (start_ok) begin
         eff.current_op = req.func;
         eff.bit_index  = 3'd0;
         eff.shift_out  = req.write_byte;
         eff.phase      = slot_start(req.func);
         tc             = '0;
         if (req.func == OP_READ) begin
            eff.shift_in = 8'd0;
         end
      end
   end

   always_comb begin
      unique case (eff.phase)
         PH_RST_LOW:  dur_raw = cfg[REG_RESET_LOW];
         PH_RST_WAIT: dur_raw = cfg[REG_PRESENCE_WAIT];
         PH_RST_TAIL: dur_raw = cfg[REG_RESET_TAIL];
         PH_WR_LOW:   dur_raw = eff.shift_out[0] ? cfg[REG_SHORT_LOW] : cfg[REG_LONG_LOW];
         PH_WR_HIGH:  dur_raw = eff.shift_out[0] ? cfg[REG_LONG_LOW] : cfg[REG_SHORT_LOW];
         PH_RD_LOW:   dur_raw = cfg[REG_READ_LOW];
         PH_RD_WAIT:  dur_raw = cfg[REG_READ_SAMPLE];
         default:     dur_raw = cfg[REG_READ_TAIL];
      endcase
   end

   // zero acts as one tick, values past the counter range are clamped
   assign raw_ext  = CMP_W'(dur_raw);
   assign dur      = (raw_ext == '0) ? CMP_W'(1) :
                     ((raw_ext > COUNT_TOP) ? COUNT_TOP : raw_ext);
   assign tick_inc = tc + 1'b1;
   assign reached  = CMP_W'(tick_inc) >= dur;

   always_comb begin
      state_nxt     = eff;
      count_nxt     = tc;
      rsp.drive_low = 1'b0;
      rsp.busy_res  = 1'b0;
      rsp.done_res  = 1'b0;
      if (eff.phase != PH_IDLE) begin
         rsp.busy_res  = 1'b1;
         rsp.drive_low = eff.phase == PH_RST_LOW || eff.phase == PH_WR_LOW ||
                         eff.phase == PH_RD_LOW;
         if (tc == '0 && eff.phase == PH_RST_TAIL) begin
            state_nxt.presence = req.line_in;
         end
         if (tc == '0 && eff.phase == PH_RD_TAIL) begin
            state_nxt.shift_in[eff.bit_index] = eff.shift_in[eff.bit_index] | req.line_in;
         end
         count_nxt = tick_inc;
         if (reached) begin
            count_nxt = '0;
            unique case (eff.phase)
               PH_RST_LOW:  state_nxt.phase = PH_RST_WAIT;
               PH_RST_WAIT: state_nxt.phase = PH_RST_TAIL;
               PH_WR_LOW:   state_nxt.phase = PH_WR_HIGH;
               PH_RD_LOW:   state_nxt.phase = PH_RD_WAIT;
               PH_RD_WAIT:  state_nxt.phase = PH_RD_TAIL;
               default: begin
                  // end of a slot
                  if (eff.current_op == OP_RESET || eff.bit_index == 3'd7) begin
                     rsp.done_res    = 1'b1;
                     state_nxt.phase = PH_IDLE;
                  end else begin
                     state_nxt.bit_index = eff.bit_index + 3'd1;
                     state_nxt.shift_out = {1'b0, eff.shift_out[7:1]};
                     state_nxt.phase     = slot_start(eff.current_op);
                  end
               end
            endcase
         end
      end
      rsp.presence_bit = state_nxt.presence;
      rsp.read_byte    = state_nxt.shift_in;
   end

endmodule

[hw/rtl/one_wire_bus_master_core.sv]
// one_wire_bus_master_core - top level of the tick-driven 1-wire bus master
// depends on owbm_pkg, owbm_csr and owbm_seq
`timescale 1ns / 1ps
//
// usage
//   each request on the req_ channel is one timing tick: the sampled bus
//   level and, while idle, an optional start of a reset, byte write or byte
//   read. every request gives exactly one response on the rsp_ channel with
//   the bus drive, busy and done flags, the presence level and the read byte.
//   slot durations in ticks are set through the csr_ write channel, which is
//   always ready; write it only while no operation runs.
//   each response follows in the cycle after its request; one request is taken
//   every cycle without a stall, set by the single sequencer state register.
//   the response register frees the request side: req_tready is high while
//   the response register is empty or being taken, so a stalled receiver
//   holds one response and then stops the request side.
//   reset brings the sequencer to idle, presence to one, read byte to zero
//   and all timing registers to their default values.
//

module one_wire_bus_master_core
   import owbm_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // start_req[0], func[2:1], write_byte[10:3], line_in[11], zero pad
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // drive_low[0], busy_res[1], done_res[2], presence_bit[3], read_byte[11:4], zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CFG_IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]       csr_data
);

   cfg_bank_type           cfg;
   req_type                req;
   seq_state_type          state_ff;
   seq_state_type          state_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   rsp_type                rsp_in;
   rsp_type                rsp_ff;
   logic                   rsp_valid_ff;
   logic                   req_accept;

   owbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign req = req_type'(req_tdata[$bits(req_type)-1:0]);

   owbm_seq #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_seq (
      .state_cur (state_ff),
      .count_cur (count_ff),
      .req       (req),
      .cfg       (cfg),
      .state_nxt (state_in),
      .count_nxt (count_in),
      .rsp       (rsp_in)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - $bits(rsp_type)){1'b0}}, rsp_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= PH_IDLE;
         state_ff.bit_index  <= 3'd0;
         state_ff.shift_out  <= 8'd0;
         state_ff.shift_in   <= 8'd0;
         state_ff.presence   <= 1'b1;
         state_ff.current_op <= OP_RESET;
         count_ff            <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff     <= state_in;
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) req_accept |=> rsp_tvalid)
      else $error("accepted request gave no response");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.done_res |-> rsp_ff.busy_res)
      else $error("done flagged outside an operation");

   assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_IDLE |-> count_ff == '0)
      else $error("tick counter left running while idle");

   assert property (@(posedge clock) disable iff (reset)
      req_accept && rsp_in.done_res |=> state_ff.phase == PH_IDLE)
      else $error("sequencer not idle after done");
`endif

endmodule
